// ===== rtl/core/ordered_handle_list_with_cursor_core_defines.svh =====
// Assertion macros shared by the handle list checker.
// No dependencies; included by the checker file only.
`ifndef ORDERED_HANDLE_LIST_WITH_CURSOR_CORE_DEFINES_SVH
`define ORDERED_HANDLE_LIST_WITH_CURSOR_CORE_DEFINES_SVH

// Same-cycle implication, reset disables the check
`define OLHC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset disables the check
`define OLHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/olhc_pkg.sv =====
// Types and constants of the ordered handle list core.
// No dependencies; used by every module of the core.
package olhc_pkg;

    localparam int OPC_W    = 3;
    localparam int HANDLE_W = 32;
    localparam int CNT_W    = 5;

    // Operation codes
    localparam logic [OPC_W-1:0] OP_APPEND  = 3'd0;
    localparam logic [OPC_W-1:0] OP_DELETE  = 3'd1;
    localparam logic [OPC_W-1:0] OP_TEST    = 3'd2;
    localparam logic [OPC_W-1:0] OP_HEAD    = 3'd3;
    localparam logic [OPC_W-1:0] OP_NEXT    = 3'd4;
    localparam logic [OPC_W-1:0] OP_CURRENT = 3'd5;

    // Request and response payloads
    typedef struct packed {
        logic [OPC_W-1:0]    opcode;
        logic [HANDLE_W-1:0] handle;
    } t_req;

    typedef struct packed {
        logic                status;
        logic                found;
        logic [HANDLE_W-1:0] cursor_handle;
        logic                cursor_valid;
        logic [CNT_W-1:0]    entry_count;
    } t_rsp;

    // Kind of response built at the end of an operation
    typedef enum logic [1:0] {
        RES_ERR    = 2'd0,
        RES_OK     = 2'd1,
        RES_FOUND  = 2'd2,
        RES_CURSOR = 2'd3
    } t_res;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic app;
        logic rd_scan;
        logic rd_shift;
        logic wr_shift;
        logic idx_inc;
        logic hit_save;
        logic del_commit;
        logic cur_step;
        logic finish;
        t_res res;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [OPC_W-1:0] op;
        logic             h_zero;
        logic             full;
        logic             empty;
        logic             hit;
        logic             scan_last;
        logic             shift_last;
        logic             out_busy;
    } t_sts;

endpackage

// ===== rtl/core/olhc_dp.sv =====
// Datapath of the handle list: entry memory, count, cursor, scan index
// and the response register. Depends on olhc_pkg.
module olhc_dp #(
    parameter int DEPTH       = 16,
    parameter int HANDLE_BITS = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  olhc_pkg::t_req  i_in_req,
    input  olhc_pkg::t_cmd  i_cmd,
    output olhc_pkg::t_sts  o_sts,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output olhc_pkg::t_rsp  o_out_rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = $clog2(DEPTH + 2);

    // Latched request
    logic [olhc_pkg::OPC_W-1:0] r_op;
    logic [HANDLE_BITS-1:0]     r_h;

    // List state; cursor kept as position plus one (0 means before first)
    logic [CW-1:0]          r_count, n_count;
    logic [PW-1:0]          r_cur, n_cur;
    logic [AW-1:0]          r_idx;
    logic [AW-1:0]          r_pos;
    logic [HANDLE_BITS-1:0] r_rd;
    logic [HANDLE_BITS-1:0] r_mem [DEPTH];

    logic                   r_ovalid;
    olhc_pkg::t_rsp         r_rsp, n_rsp;

    logic                   empty;
    logic [CW-1:0]          idx_p1;
    logic [PW-1:0]          count_pw;
    logic [PW-1:0]          cur_m1;
    logic [PW-1:0]          del_cur;
    logic [AW-1:0]          rd_addr;
    logic                   rd_en;
    logic                   cur_ok;

    assign empty    = (r_count == '0);
    assign idx_p1   = CW'(r_idx) + CW'(1);
    assign count_pw = PW'(r_count);

    // Status toward the controller
    always_comb begin
        o_sts.op         = r_op;
        o_sts.h_zero     = (r_h == '0);
        o_sts.full       = (r_count >= CW'(DEPTH));
        o_sts.empty      = empty;
        o_sts.hit        = (r_rd == r_h);
        o_sts.scan_last  = (idx_p1 == r_count);
        o_sts.shift_last = (idx_p1 >= r_count);
        o_sts.out_busy   = r_ovalid && !i_out_ready;
    end

    // Cursor update: append to empty, head/next step, delete adjust
    always_comb begin
        del_cur = r_cur;
        if ((PW'(r_pos) + PW'(1)) < r_cur) begin
            del_cur = r_cur - PW'(1);
        end
        if (del_cur >= count_pw) begin
            del_cur = count_pw;
        end

        n_cur = r_cur;
        if (i_cmd.app && empty) begin
            n_cur = PW'(1);
        end else if (i_cmd.cur_step) begin
            if ((r_op == olhc_pkg::OP_HEAD) && !empty) begin
                n_cur = PW'(1);
            end else if ((r_op == olhc_pkg::OP_NEXT) && !empty && (r_cur <= count_pw)) begin
                n_cur = r_cur + PW'(1);
            end
        end else if (i_cmd.del_commit) begin
            n_cur = del_cur;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.app) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.del_commit) begin
            n_count = r_count - CW'(1);
        end
    end

    // Read address select; cursor reads use the freshly updated cursor
    assign cur_m1 = n_cur - PW'(1);
    always_comb begin
        rd_addr = r_idx;
        if (i_cmd.rd_shift) begin
            rd_addr = r_idx + AW'(1);
        end else if (i_cmd.cur_step) begin
            rd_addr = cur_m1[AW-1:0];
        end
    end
    assign rd_en = i_cmd.rd_scan || i_cmd.rd_shift || i_cmd.cur_step;

    // Entry memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.app) begin
            r_mem[r_count[AW-1:0]] <= r_h;
        end else if (i_cmd.wr_shift) begin
            r_mem[r_idx] <= r_rd;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // Request latch and scan index
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_in_req.opcode;
            r_h  <= HANDLE_BITS'(i_in_req.handle);
        end
        if (i_cmd.load) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc || i_cmd.wr_shift) begin
            r_idx <= r_idx + AW'(1);
        end
        if (i_cmd.hit_save) begin
            r_pos <= r_idx;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_cur    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_cur   <= n_cur;
            if (i_cmd.finish) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Response build
    assign cur_ok = (r_cur != '0) && (r_cur <= count_pw);
    always_comb begin
        n_rsp               = '0;
        n_rsp.entry_count   = olhc_pkg::CNT_W'(r_count);
        unique case (i_cmd.res)
            olhc_pkg::RES_ERR: begin
                n_rsp.status = 1'b1;
            end
            olhc_pkg::RES_OK: begin
                n_rsp.status = 1'b0;
            end
            olhc_pkg::RES_FOUND: begin
                n_rsp.found = 1'b1;
            end
            olhc_pkg::RES_CURSOR: begin
                n_rsp.cursor_valid  = cur_ok;
                n_rsp.cursor_handle = cur_ok ? olhc_pkg::HANDLE_W'(r_rd) : '0;
            end
            default: begin
                n_rsp.status = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_rsp   = r_rsp;

endmodule

// ===== rtl/core/olhc_ctrl.sv =====
// Controller of the handle list: sequences scan, shift and cursor steps.
// Depends on olhc_pkg.
module olhc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  olhc_pkg::t_sts  i_sts,
    output olhc_pkg::t_cmd  o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DISPATCH = 7'b0000010,
        S_SCAN_RD  = 7'b0000100,
        S_SCAN_CMP = 7'b0001000,
        S_SHIFT_RD = 7'b0010000,
        S_SHIFT_WR = 7'b0100000,
        S_DONE     = 7'b1000000
    } t_state;

    t_state          r_state, n_state;
    olhc_pkg::t_res  r_res, n_res;
    logic            is_test;

    assign o_in_ready = (r_state == S_IDLE);
    assign is_test    = (i_sts.op == olhc_pkg::OP_TEST);

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_res       = r_res;
        o_cmd       = '0;
        o_cmd.res   = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_state = S_DONE;
                n_res   = olhc_pkg::RES_ERR;
                unique case (i_sts.op)
                    olhc_pkg::OP_APPEND: begin
                        if (!i_sts.h_zero && !i_sts.full) begin
                            o_cmd.app = 1'b1;
                            n_res     = olhc_pkg::RES_OK;
                        end
                    end
                    olhc_pkg::OP_DELETE, olhc_pkg::OP_TEST: begin
                        if (!i_sts.h_zero) begin
                            if (i_sts.empty) begin
                                n_res = is_test ? olhc_pkg::RES_OK : olhc_pkg::RES_ERR;
                            end else begin
                                n_state = S_SCAN_RD;
                            end
                        end
                    end
                    olhc_pkg::OP_HEAD, olhc_pkg::OP_NEXT, olhc_pkg::OP_CURRENT: begin
                        o_cmd.cur_step = 1'b1;
                        n_res          = olhc_pkg::RES_CURSOR;
                    end
                    default: begin
                        n_res = olhc_pkg::RES_ERR;
                    end
                endcase
            end
            S_SCAN_RD: begin
                o_cmd.rd_scan = 1'b1;
                n_state       = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (i_sts.hit) begin
                    if (is_test) begin
                        n_res   = olhc_pkg::RES_FOUND;
                        n_state = S_DONE;
                    end else begin
                        o_cmd.hit_save = 1'b1;
                        n_state        = S_SHIFT_RD;
                    end
                end else if (i_sts.scan_last) begin
                    n_res   = is_test ? olhc_pkg::RES_OK : olhc_pkg::RES_ERR;
                    n_state = S_DONE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SCAN_RD;
                end
            end
            S_SHIFT_RD: begin
                if (i_sts.shift_last) begin
                    o_cmd.del_commit = 1'b1;
                    n_res            = olhc_pkg::RES_OK;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.rd_shift = 1'b1;
                    n_state        = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                o_cmd.wr_shift = 1'b1;
                n_state        = S_SHIFT_RD;
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_res   <= olhc_pkg::RES_OK;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
        end
    end

endmodule

// ===== rtl/core/ordered_handle_list_with_cursor_core.sv =====
// Top level of the ordered handle list with cursor.
// Depends on olhc_pkg, olhc_ctrl and olhc_dp.
//
//   Channel  | Handshake                 | Payload
//   ---------+---------------------------+------------------------------
//   request  | i_in_valid / o_in_ready   | i_in_req  (olhc_pkg::t_req)
//   response | o_out_valid / i_out_ready | o_out_rsp (olhc_pkg::t_rsp)
//
// Append, head, next, current, zero handle and bad opcode pass through dispatch
// straight to done. Delete and test scan the entry memory entry by entry (read,
// compare) up to the match; a delete then moves the rest of the tail down entry
// by entry (read, write) through the single read port of the entry memory.
// Reset clears count, cursor, response valid and controller state; no clearing pass runs over the memory.
// A stalled response holds in the output register; the next request is taken
// meanwhile and waits for that register before it completes.
module ordered_handle_list_with_cursor_core #(
    parameter int DEPTH       = 16,
    parameter int HANDLE_BITS = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  olhc_pkg::t_req  i_in_req,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output olhc_pkg::t_rsp  o_out_rsp
);

    olhc_pkg::t_cmd cmd;
    olhc_pkg::t_sts sts;

    // Sequencer
    olhc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // List storage and response register
    olhc_dp #(
        .DEPTH       (DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_req    (i_in_req),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp)
    );

endmodule

// ===== rtl/core/olhc_checker.sv =====
// Port-level checks of the handle list core, bound to its top level.
// Depends on olhc_pkg and the core's assertion macro header.
`include "ordered_handle_list_with_cursor_core_defines.svh"

module olhc_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_ready,
    input  logic            i_out_valid,
    input  logic            i_out_ready,
    input  olhc_pkg::t_rsp  i_rsp
);

    // A stalled response keeps its value
    `OLHC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_rsp), "response changed while stalled")

    // One request at a time: ready drops right after an accept
    `OLHC_ASSERT_NEXT(a_one_req, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "request taken while another is in work")

    // A cursor answer carries a stored, nonzero handle and no error
    `OLHC_ASSERT_IMPL(a_cur_ok, i_clk, i_rst_n, i_out_valid && i_rsp.cursor_valid, (i_rsp.cursor_handle != '0) && !i_rsp.status && !i_rsp.found, "bad cursor answer")

    // A membership hit is never an error
    `OLHC_ASSERT_IMPL(a_found_ok, i_clk, i_rst_n, i_out_valid && i_rsp.found, !i_rsp.status, "hit flagged as error")

endmodule

bind ordered_handle_list_with_cursor_core olhc_checker u_olhc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_rsp       (o_out_rsp)
);
